// ===== rtl/pwcb_pkg.sv =====
// Package for the print write-combining buffer: item types, queue entry,
// state encodings, register indexes and fixed widths. No dependencies.
package pwcb_pkg;

    localparam int unsigned MAX_DEPTH     = 64;
    localparam int unsigned COUNT_W       = 7;
    localparam int unsigned WAIT_W        = 4;
    localparam int unsigned ADDR_W        = 7;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CFG_DATA_W    = 8;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned QUEUE_PTR_W   = 1;
    localparam int unsigned QUEUE_CNT_W   = 2;

    localparam logic [WAIT_W-1:0] FLUSH_WAIT_RESET     = 4'd5;
    localparam logic [ADDR_W-1:0] DEVICE_ADDRESS_RESET = 7'd0;
    localparam logic [WAIT_W-1:0] WAIT_AFTER_FLUSH     = 4'd1;

    localparam logic [CFG_INDEX_W-1:0] CFG_FLUSH_WAIT     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 1'd1;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_REFUSED = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic [ADDR_W-1:0] dest_address;
    } out_item_t;

    typedef enum logic {
        OP_REFUSE = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [COUNT_W-1:0] count;
    } job_t;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_DRAIN = 1'b1
    } back_state_t;

endpackage

// ===== rtl/pwcb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwcb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pwcb_front.sv =====
// Front end: accepts items, appends bytes, tracks fill, wait and pending state,
// and queues refusal and flush jobs. Depends on pwcb_pkg.
module pwcb_front #(
    parameter int unsigned BUFFER_DEPTH = pwcb_pkg::MAX_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  pwcb_pkg::in_item_t                item,
    input  logic [pwcb_pkg::WAIT_W-1:0]       flush_wait,
    output logic                              mem_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0]   mem_waddr,
    output logic [pwcb_pkg::BYTE_W-1:0]       mem_wdata,
    output logic                              push,
    output pwcb_pkg::job_t                    push_job
);

    localparam int unsigned FILL_W = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned AW     = $clog2(BUFFER_DEPTH);

    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [pwcb_pkg::WAIT_W-1:0] wait_reg, wait_next;
    logic                        pending_reg, pending_next;
    logic                        full;

    assign full      = (fill_reg == FILL_W'(BUFFER_DEPTH));
    assign mem_waddr = fill_reg[AW-1:0];
    assign mem_wdata = item.data_byte;

    always_comb
    begin
        fill_next      = fill_reg;
        wait_next      = wait_reg;
        pending_next   = pending_reg;
        mem_we         = 1'b0;
        push           = 1'b0;
        push_job.op    = pwcb_pkg::OP_REFUSE;
        push_job.count = '0;
        if (accept)
        begin
            if (item.cmd == pwcb_pkg::CMD_WRITE)
            begin
                if (full)
                begin
                    push = 1'b1;
                end
                else
                begin
                    mem_we       = 1'b1;
                    fill_next    = fill_reg + FILL_W'(1);
                    pending_next = 1'b1;
                end
            end
            else if (pending_reg)
            begin
                if (fill_reg == '0)
                begin
                    wait_next    = '0;
                    pending_next = 1'b0;
                end
                else if (!full && (wait_reg < flush_wait))
                begin
                    wait_next = wait_reg + pwcb_pkg::WAIT_W'(1);
                end
                else
                begin
                    push           = 1'b1;
                    push_job.op    = pwcb_pkg::OP_FLUSH;
                    push_job.count = pwcb_pkg::COUNT_W'(fill_reg);
                    fill_next      = '0;
                    wait_next      = pwcb_pkg::WAIT_AFTER_FLUSH;
                    pending_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            wait_reg    <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            wait_reg    <= wait_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== rtl/pwcb_queue.sv =====
// Two-entry job queue between front and back end. Depends on pwcb_pkg.
module pwcb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pwcb_pkg::job_t push_job,
    input  logic           pop,
    output pwcb_pkg::job_t head,
    output logic           empty
);

    pwcb_pkg::job_t                   slot_reg [pwcb_pkg::QUEUE_DEPTH];
    logic [pwcb_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pwcb_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pwcb_pkg::QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                             do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && (cnt_reg != pwcb_pkg::QUEUE_CNT_W'(pwcb_pkg::QUEUE_DEPTH));
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + pwcb_pkg::QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + pwcb_pkg::QUEUE_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + pwcb_pkg::QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - pwcb_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/pwcb_back.sv =====
// Back end: takes jobs off the queue, emits refusals and drains the byte store
// one entry a cycle as a burst. Depends on pwcb_pkg.
module pwcb_back #(
    parameter int unsigned BUFFER_DEPTH = pwcb_pkg::MAX_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  pwcb_pkg::job_t                   q_head,
    output logic                             pop,
    output logic                             mem_re,
    output logic [$clog2(BUFFER_DEPTH)-1:0]  mem_raddr,
    input  logic [pwcb_pkg::BYTE_W-1:0]      mem_rdata,
    input  logic [pwcb_pkg::ADDR_W-1:0]      device_address,
    output logic                             active,
    output logic                             result_valid,
    output pwcb_pkg::out_item_t              result
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    pwcb_pkg::back_state_t        state_reg, state_next;
    logic [pwcb_pkg::COUNT_W-1:0] idx_reg, idx_next;
    logic [pwcb_pkg::COUNT_W-1:0] n_reg, n_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic                         rd_last_reg, rd_last_next;
    logic                         refuse_reg, refuse_next;
    logic                         at_last;

    assign at_last = ((idx_reg + pwcb_pkg::COUNT_W'(1)) == n_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pwcb_pkg::BK_IDLE:
            begin
                if (!q_empty && (q_head.op == pwcb_pkg::OP_FLUSH))
                begin
                    state_next = pwcb_pkg::BK_DRAIN;
                end
            end
            pwcb_pkg::BK_DRAIN:
            begin
                if (at_last)
                begin
                    state_next = pwcb_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = pwcb_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop           = 1'b0;
        mem_re        = 1'b0;
        idx_next      = idx_reg;
        n_next        = n_reg;
        rd_valid_next = 1'b0;
        rd_last_next  = 1'b0;
        refuse_next   = 1'b0;
        case (state_reg)
            pwcb_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (q_head.op == pwcb_pkg::OP_FLUSH)
                    begin
                        idx_next = '0;
                        n_next   = q_head.count;
                    end
                    else
                    begin
                        refuse_next = 1'b1;
                    end
                end
            end
            pwcb_pkg::BK_DRAIN:
            begin
                mem_re        = 1'b1;
                rd_valid_next = 1'b1;
                rd_last_next  = at_last;
                idx_next      = idx_reg + pwcb_pkg::COUNT_W'(1);
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign mem_raddr = idx_reg[AW-1:0];
    assign active    = (state_reg != pwcb_pkg::BK_IDLE);

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        n_reg   <= n_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pwcb_pkg::BK_IDLE;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            refuse_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            rd_last_reg  <= rd_last_next;
            refuse_reg   <= refuse_next;
        end
    end

    assign result_valid = rd_valid_reg || refuse_reg;

    always_comb
    begin
        if (rd_valid_reg)
        begin
            result.kind         = pwcb_pkg::KIND_DATA;
            result.out_byte     = mem_rdata;
            result.last         = rd_last_reg;
            result.dest_address = device_address;
        end
        else
        begin
            result.kind         = pwcb_pkg::KIND_REFUSED;
            result.out_byte     = '0;
            result.last         = 1'b1;
            result.dest_address = '0;
        end
    end

endmodule

// ===== rtl/print_write_combine_buffer_top.sv =====
// Top level of the print write-combining buffer: configuration registers,
// front end, job queue, back end and byte store. Depends on pwcb_pkg and all pwcb_* modules.
//
// Bytes written with cmd = write collect in a store of BUFFER_DEPTH entries;
// timer ticks (cmd = tick) age them and, once flush_wait ticks have passed or
// the store is full, emit the whole store as one burst with last on its final
// byte. A write to a full store returns one refused item. Items are taken when
// start is high and busy is low. A write or a tick that flushes nothing leaves
// busy low, so the next item may follow right away. A flushing tick or a
// refused write is handed through a short job queue to the back end; busy
// stays high while a job waits or a burst drains. A burst keeps busy high
// while the back end takes the job and then reads the store once per byte
// through the single read port; its items appear on the result port one per
// cycle, each for exactly one cycle with result_valid high. A refusal passes
// the job queue and a back-end register before it appears. The receiver
// has no way to stall: it must take every item in the cycle it is shown.
// Configuration writes are always ready; write them only while the block is
// idle. Index 0 is flush_wait (low 4 bits), index 1 is device_address
// (low 7 bits).
module print_write_combine_buffer_top #(
    parameter int unsigned BUFFER_DEPTH = pwcb_pkg::MAX_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  pwcb_pkg::in_item_t                  item,
    output logic                                result_valid,
    output pwcb_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pwcb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pwcb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    logic [pwcb_pkg::WAIT_W-1:0] flush_wait_reg;
    logic [pwcb_pkg::ADDR_W-1:0] dev_addr_reg;

    logic                        accept;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [pwcb_pkg::BYTE_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [pwcb_pkg::BYTE_W-1:0] mem_rdata;
    logic                        push;
    pwcb_pkg::job_t              push_job;
    logic                        pop;
    pwcb_pkg::job_t              q_head;
    logic                        q_empty;
    logic                        back_active;

    // Hold off new items while a job waits or a burst drains.
    assign busy      = !q_empty || back_active;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes drop the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_wait_reg <= pwcb_pkg::FLUSH_WAIT_RESET;
            dev_addr_reg   <= pwcb_pkg::DEVICE_ADDRESS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pwcb_pkg::CFG_FLUSH_WAIT:
                begin
                    flush_wait_reg <= cfg_data[pwcb_pkg::WAIT_W-1:0];
                end
                pwcb_pkg::CFG_DEVICE_ADDRESS:
                begin
                    dev_addr_reg <= cfg_data[pwcb_pkg::ADDR_W-1:0];
                end
                default:
                begin
                    flush_wait_reg <= flush_wait_reg;
                end
            endcase
        end
    end

    // Front end: classify each item, append bytes, queue refusals and flushes.
    pwcb_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .flush_wait (flush_wait_reg),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .push       (push),
        .push_job   (push_job)
    );

    pwcb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // Byte store: written by the front end, read by the back end during a burst.
    pwcb_ram #(
        .WIDTH (pwcb_pkg::BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Back end: emit refusals and drain bursts in store order.
    pwcb_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .pop            (pop),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .device_address (dev_addr_reg),
        .active         (back_active),
        .result_valid   (result_valid),
        .result         (result)
    );

endmodule
